### src/multi_channel_soft_timer_bank_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timer bank
// Concurrent assertion wrappers that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_SOFT_TIMER_BANK_ASSERT_SVH
`define MULTI_CHANNEL_SOFT_TIMER_BANK_ASSERT_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define MCSTB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);
// Checked on every clock edge, reset included.
`define MCSTB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define MCSTB_ASSERT(lbl, clk, rstn, prop, msg)
`define MCSTB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### src/mcstb_pkg.sv
// ----------------------------------------------------------------------------
// Timer bank package
// Operation and mode codes and the record types shared by the timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package mcstb_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_CHANGE = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  localparam logic [1:0] MODE_ONESHOT = 2'd0;
  localparam logic [1:0] MODE_MULTI   = 2'd1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [DataW-1:0] period;
    logic [DataW-1:0] remain;
    logic [DataW-1:0] shots;
  } slot_rec_t;

  typedef struct packed {
    logic mode;
    logic period;
    logic remain;
    logic shots;
  } slot_we_t;

  typedef struct packed {
    logic [DataW-1:0] remain;
    logic [DataW-1:0] shots;
    logic             fire;
    logic             stop;
  } alu_res_t;

endpackage

`default_nettype wire

### src/mcstb_slot_mem.sv
// ----------------------------------------------------------------------------
// Timer slot store
// Per-slot mode, period, remaining count and shot count, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mcstb_slot_mem
  import mcstb_pkg::*;
#(
  parameter int NUM_SLOTS = 8,
  parameter int SLOT_W    = 3
) (
  input  wire logic              clk_i,
  input  wire slot_we_t          we_i,
  input  wire logic [SLOT_W-1:0] waddr_i,
  input  wire slot_rec_t         wdata_i,
  input  wire logic              re_i,
  input  wire logic [SLOT_W-1:0] raddr_i,
  output slot_rec_t              rdata_o
);

  logic [1:0]       mode_mem   [NUM_SLOTS];
  logic [DataW-1:0] period_mem [NUM_SLOTS];
  logic [DataW-1:0] remain_mem [NUM_SLOTS];
  logic [DataW-1:0] shots_mem  [NUM_SLOTS];
  slot_rec_t        rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i.mode) begin
      mode_mem[waddr_i] <= wdata_i.mode;
    end
    if (we_i.period) begin
      period_mem[waddr_i] <= wdata_i.period;
    end
    if (we_i.remain) begin
      remain_mem[waddr_i] <= wdata_i.remain;
    end
    if (we_i.shots) begin
      shots_mem[waddr_i] <= wdata_i.shots;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q.mode   <= mode_mem[raddr_i];
      rdata_q.period <= period_mem[raddr_i];
      rdata_q.remain <= remain_mem[raddr_i];
      rdata_q.shots  <= shots_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/mcstb_tick_alu.sv
// ----------------------------------------------------------------------------
// Timer tick unit
// Subtracts the tick step from one slot's count and decides firing, reload
// and stop for that slot.
// ----------------------------------------------------------------------------
`default_nettype none

module mcstb_tick_alu
  import mcstb_pkg::*;
(
  input  wire slot_rec_t        slot_i,
  input  wire logic [DataW-1:0] step_i,
  output alu_res_t              res_o
);

  logic [DataW:0] diff;
  logic           fire;

  assign diff = {1'b0, slot_i.remain} - {1'b0, step_i};
  assign fire = diff[DataW] || (diff[DataW-1:0] == '0);

  always_comb begin
    res_o.remain = diff[DataW-1:0];
    res_o.shots  = slot_i.shots;
    res_o.fire   = fire;
    res_o.stop   = 1'b0;
    if (fire) begin
      res_o.remain = slot_i.period;
      case (slot_i.mode)
        MODE_ONESHOT: begin
          res_o.stop = 1'b1;
        end
        MODE_MULTI: begin
          if (slot_i.shots > DataW'(1)) begin
            res_o.shots = slot_i.shots - DataW'(1);
          end else begin
            res_o.stop = 1'b1;
          end
        end
        default: begin
          res_o.stop = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/multi_channel_soft_timer_bank.sv
// ----------------------------------------------------------------------------
// Multi-channel soft timer bank
// A bank of timer slots driven by tick, add, remove, change and query
// operations, with one shared tick unit swept over the slots.
// ----------------------------------------------------------------------------
// Usage: operations enter on the s_axis channel, one transaction each, with
// the operation code in tuser. Every operation yields exactly one result
// transaction on the m_axis channel. The tick step is to be written over
// the APB port only while the bank is idle; the bank does not enforce this.
// A tick result is loaded into the output register once the single tick
// unit has visited every slot, one slot per cycle behind the registered read
// of the slot store. An add scans the active bits one slot a cycle until it
// finds a free slot or reaches the last one. The input is ready only while
// no operation is in progress, so the next operation is accepted at the
// earliest in the cycle after the previous result is loaded.
// Reset clears every active bit, the tick step and the result valid flag; the
// slot store is not cleared, as data read from inactive slots is never used.
// When the receiver stalls, the finished result waits in the output register;
// the next operation is accepted and processed, and its result waits inside
// until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_channel_soft_timer_bank_assert.svh"

module multi_channel_soft_timer_bank
  import mcstb_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [3:0] slot_index, [35:4] period_ticks, [37:36] timer_mode,
  // [69:38] shot_count, [71:70] zero
  input  wire logic [71:0] s_axis_tdata_i,
  // [2:0] op
  input  wire logic [2:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [0] status, [3:1] granted_slot, [11:4] fired_mask, [12] slot_active,
  // [13] irq_enabled, [15:14] zero
  output logic [15:0]      m_axis_tdata_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TICK = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_MISC = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [NUM_SLOTS-1:0] slot_on_q, slot_on_d;
  logic [DataW-1:0]     tick_step_q;

  logic [2:0]           op_q;
  logic [3:0]           idx_q;
  logic [DataW-1:0]     period_q;
  logic [1:0]           mode_q;
  logic [DataW-1:0]     shots_q;

  logic                 status_q, status_d;
  logic [2:0]           granted_q, granted_d;
  logic [7:0]           fired_q, fired_d;
  logic                 active_q, active_d;

  logic                 out_valid_q;
  logic [15:0]          out_data_q;

  logic                 in_fire;
  logic                 cfg_write;
  logic                 out_load;
  logic                 idx_ok;
  logic                 add_hit;
  logic [SLOT_W-1:0]    idx_slot;
  logic [SLOT_W-1:0]    cnt_slot;
  logic [SLOT_W-1:0]    ex_slot;

  slot_we_t             mem_we;
  logic [SLOT_W-1:0]    mem_waddr;
  slot_rec_t            mem_wdata;
  logic                 mem_re;
  slot_rec_t            mem_rdata;
  alu_res_t             alu_res;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_write       = psel && penable && pwrite && pready;
  assign pready          = 1'b1;
  assign prdata          = (paddr[2] == 1'b0) ? tick_step_q : '0;

  assign idx_ok   = (32'(idx_q) < NUM_SLOTS);
  assign idx_slot = SLOT_W'(idx_q);
  assign cnt_slot = SLOT_W'(cnt_q);
  assign ex_slot  = SLOT_W'(cnt_q - CNT_W'(1));
  assign add_hit  = (state_q == ST_ADD) && !slot_on_q[cnt_slot];
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);

  mcstb_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (cnt_slot),
    .rdata_o (mem_rdata)
  );

  mcstb_tick_alu u_tick_alu (
    .slot_i (mem_rdata),
    .step_i (tick_step_q),
    .res_o  (alu_res)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    slot_on_d = slot_on_q;
    status_d  = status_q;
    granted_d = granted_q;
    fired_d   = fired_q;
    active_d  = active_q;
    mem_we    = '0;
    mem_waddr = ex_slot;
    mem_re    = 1'b0;
    mem_wdata.mode   = mode_q;
    mem_wdata.period = period_q;
    mem_wdata.remain = period_q;
    mem_wdata.shots  = shots_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_d     = '0;
          status_d  = 1'b0;
          granted_d = '0;
          fired_d   = '0;
          active_d  = 1'b0;
          case (s_axis_tuser_i)
            OP_TICK: state_d = ST_TICK;
            OP_ADD:  state_d = ST_ADD;
            default: state_d = ST_MISC;
          endcase
        end
      end
      ST_TICK: begin
        mem_re = (cnt_q < CNT_W'(NUM_SLOTS));
        mem_wdata.remain = alu_res.remain;
        mem_wdata.shots  = alu_res.shots;
        if ((cnt_q != '0) && slot_on_q[ex_slot]) begin
          mem_we.remain = 1'b1;
          mem_we.shots  = 1'b1;
          if (alu_res.fire) begin
            fired_d = fired_q | (8'(1) << ex_slot);
          end
          if (alu_res.stop) begin
            slot_on_d[ex_slot] = 1'b0;
          end
        end
        if (cnt_q == CNT_W'(NUM_SLOTS)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_ADD: begin
        mem_waddr = cnt_slot;
        if (add_hit) begin
          mem_we              = '1;
          slot_on_d[cnt_slot] = 1'b1;
          granted_d           = 3'(cnt_q);
          state_d             = ST_DONE;
        end else if (cnt_q == CNT_W'(NUM_SLOTS - 1)) begin
          status_d = 1'b1;
          state_d  = ST_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_MISC: begin
        mem_waddr = idx_slot;
        state_d   = ST_DONE;
        case (op_q)
          OP_REMOVE: begin
            if (idx_ok) begin
              slot_on_d[idx_slot] = 1'b0;
            end else begin
              status_d = 1'b1;
            end
          end
          OP_CHANGE: begin
            if (idx_ok && slot_on_q[idx_slot]) begin
              mem_we.period = 1'b1;
              mem_we.remain = 1'b1;
            end else begin
              status_d = 1'b1;
            end
          end
          OP_QUERY: begin
            if (idx_ok) begin
              active_d = slot_on_q[idx_slot];
            end else begin
              status_d = 1'b1;
            end
          end
          default: begin
            status_d = 1'b1;
          end
        endcase
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      slot_on_q   <= '0;
      tick_step_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      slot_on_q <= slot_on_d;
      if (cfg_write && (paddr[2] == 1'b0)) begin
        tick_step_q <= pwdata;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    granted_q <= granted_d;
    fired_q   <= fired_d;
    active_q  <= active_d;
    if (in_fire) begin
      op_q     <= s_axis_tuser_i;
      idx_q    <= s_axis_tdata_i[3:0];
      period_q <= s_axis_tdata_i[35:4];
      mode_q   <= s_axis_tdata_i[37:36];
      shots_q  <= s_axis_tdata_i[69:38];
    end
    if (out_load) begin
      out_data_q <= {2'b00, |slot_on_q, active_q, fired_q, granted_q, status_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `MCSTB_ASSERT(a_tick_starts_sweep, clk_i, rst_ni,
    (in_fire && (s_axis_tuser_i == OP_TICK)) |=> (state_q == ST_TICK && cnt_q == '0),
    "tick did not start the slot sweep")
  `MCSTB_ASSERT(a_result_from_done, clk_i, rst_ni,
    $rose(m_axis_tvalid_o) |-> ($past(state_q) == ST_DONE),
    "result appeared without a finished operation")
  `MCSTB_ASSERT(a_sweep_bounded, clk_i, rst_ni,
    (state_q == ST_TICK || state_q == ST_ADD) |-> (cnt_q <= CNT_W'(NUM_SLOTS)),
    "slot counter ran past the bank")
  `MCSTB_ASSERT(a_add_grants_active, clk_i, rst_ni,
    add_hit |=> (slot_on_q[$past(cnt_slot)] && state_q == ST_DONE),
    "granted slot is not active after add")
  `MCSTB_ASSERT_ALWAYS(a_idle_in_reset, clk_i,
    !rst_ni |=> (state_q == ST_IDLE && !m_axis_tvalid_o),
    "bank not idle during reset")

endmodule

`default_nettype wire

### test/multi_channel_soft_timer_bank_test.sv
// ----------------------------------------------------------------------------
// Timer bank testbench
// Drives tick, add, remove, change, query and unused operation codes into
// the timer bank under several tick step settings, with random sender gaps
// and receiver stalls. Each result transaction is checked field by field
// against the in-bench slot bank model or a directed row's fixed result.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_soft_timer_bank_test;
  import mcstb_pkg::*;

  localparam int NUM_SLOTS = 8;
  localparam int RAND_PER_PHASE = 285;
  localparam int DRAIN_CYCLES = NUM_SLOTS + 8;
  localparam logic [2:0] TICK_STEP_ADDR = 3'd0;
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_MID = 3'd6;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam logic [1:0] MODE_PERIODIC = 2'd2;
  localparam logic [1:0] MODE_PERIODIC_ALT = 2'd3;

  typedef struct packed {
    logic       irq;
    logic       active;
    logic [7:0] fired;
    logic [2:0] granted;
    logic       status;
  } timer_resp_t;

  typedef struct {
    logic [2:0]  op;
    logic [3:0]  idx;
    logic [31:0] period;
    logic [1:0]  mode;
    logic [31:0] shots;
    bit          typed;
    timer_resp_t resp;
  } op_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  multi_channel_soft_timer_bank #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bit [NUM_SLOTS-1:0] slot_on_q;
  logic [1:0]         slot_mode_q[NUM_SLOTS];
  logic [31:0]        slot_period_q[NUM_SLOTS];
  longint             slot_left_q[NUM_SLOTS];
  logic [31:0]        slot_shots_q[NUM_SLOTS];
  logic [31:0]        tick_step_q;

  timer_resp_t pending_results[$];
  op_row_t     directed_ops[$];
  int          mismatch_cnt;
  int          burst_left;
  int          ops_sent;
  int          firing_ticks;
  int          full_rejects;
  int          step_settings;

  function automatic timer_resp_t apply_timer_op(input logic [2:0] op, input logic [3:0] idx,
                                                 input logic [31:0] period,
                                                 input logic [1:0] mode,
                                                 input logic [31:0] shots);
    timer_resp_t r;
    bit          idx_ok;
    r = '0;
    idx_ok = idx < NUM_SLOTS;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_on_q[i]) begin
            slot_left_q[i] = slot_left_q[i] - longint'({32'd0, tick_step_q});
            if (slot_left_q[i] <= 0) begin
              r.fired[i] = 1'b1;
              if (slot_mode_q[i] == MODE_ONESHOT) begin
                slot_on_q[i] = 1'b0;
              end else if (slot_mode_q[i] == MODE_MULTI) begin
                if (slot_shots_q[i] > 32'd1) begin
                  slot_shots_q[i] = slot_shots_q[i] - 32'd1;
                  slot_left_q[i] = longint'({32'd0, slot_period_q[i]});
                end else begin
                  slot_on_q[i] = 1'b0;
                end
              end else begin
                slot_left_q[i] = longint'({32'd0, slot_period_q[i]});
              end
            end
          end
        end
      end
      OP_ADD: begin
        r.status = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!slot_on_q[i] && r.status) begin
            slot_on_q[i] = 1'b1;
            slot_mode_q[i] = mode;
            slot_period_q[i] = period;
            slot_left_q[i] = longint'({32'd0, period});
            slot_shots_q[i] = shots;
            r.granted = 3'(i);
            r.status = 1'b0;
          end
        end
      end
      OP_REMOVE: begin
        if (idx_ok) slot_on_q[idx[2:0]] = 1'b0;
        else r.status = 1'b1;
      end
      OP_CHANGE: begin
        if (idx_ok && slot_on_q[idx[2:0]]) begin
          slot_period_q[idx[2:0]] = period;
          slot_left_q[idx[2:0]] = longint'({32'd0, period});
        end else begin
          r.status = 1'b1;
        end
      end
      OP_QUERY: begin
        if (idx_ok) r.active = slot_on_q[idx[2:0]];
        else r.status = 1'b1;
      end
      default: r.status = 1'b1;
    endcase
    r.irq = |slot_on_q;
    return r;
  endfunction

  function automatic timer_resp_t mk_resp(input logic st, input logic [2:0] gr,
                                          input logic [7:0] fm, input logic ac,
                                          input logic ir);
    timer_resp_t r;
    r.status = st;
    r.granted = gr;
    r.fired = fm;
    r.active = ac;
    r.irq = ir;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic add_row(input logic [2:0] op, input logic [3:0] idx, input logic [31:0] period,
                         input logic [1:0] mode, input logic [31:0] shots, input bit typed,
                         input timer_resp_t resp);
    op_row_t row;
    row.op = op;
    row.idx = idx;
    row.period = period;
    row.mode = mode;
    row.shots = shots;
    row.typed = typed;
    row.resp = resp;
    directed_ops.push_back(row);
  endtask

  task automatic issue_op(input op_row_t row);
    timer_resp_t r;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= row.op;
    s_axis_tdata_i <= {2'b00, row.shots, row.mode, row.period, row.idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = apply_timer_op(row.op, row.idx, row.period, row.mode, row.shots);
    if (row.op == OP_TICK && r.fired != '0) firing_ticks++;
    if (row.op == OP_ADD && r.status) full_rejects++;
    ops_sent++;
    pending_results.push_back(row.typed ? row.resp : r);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_tick_step(input logic [31:0] step);
    logic [31:0] rd;
    apb_access(1'b1, TICK_STEP_ADDR, step, rd);
    apb_access(1'b0, TICK_STEP_ADDR, '0, rd);
    if (rd !== step)
      note_mismatch($sformatf("tick_step readback expected %h actual %h", step, rd));
    tick_step_q = step;
    step_settings++;
  endtask

  function automatic op_row_t random_row(input logic [31:0] step);
    op_row_t     row;
    int unsigned pick;
    longint      wide;
    pick = $urandom_range(0, 99);
    if (pick < 35) row.op = OP_TICK;
    else if (pick < 60) row.op = OP_ADD;
    else if (pick < 70) row.op = OP_REMOVE;
    else if (pick < 80) row.op = OP_CHANGE;
    else if (pick < 95) row.op = OP_QUERY;
    else row.op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
    row.idx = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, NUM_SLOTS - 1));
    case ($urandom_range(0, 7))
      0: row.period = '0;
      1: row.period = 32'($urandom_range(1, 8));
      2, 3: begin
        wide = longint'({32'd0, step}) * longint'($urandom_range(1, 6));
        row.period = (wide > 64'hFFFF_FFFF) ? 32'($urandom) : wide[31:0];
      end
      4: row.period = 32'hFFFF_FFFF;
      5: begin
        wide = longint'({32'd0, step}) + longint'($urandom_range(0, 3));
        row.period = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
      end
      default: row.period = 32'($urandom);
    endcase
    row.mode = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0: row.shots = '0;
      1: row.shots = 32'd1;
      2, 3: row.shots = 32'($urandom_range(2, 5));
      4: row.shots = 32'hFFFF_FFFF;
      default: row.shots = 32'($urandom);
    endcase
    row.typed = 1'b0;
    row.resp = '0;
    return row;
  endfunction

  int stall_span;
  int stall_run;
  int stall_style;

  always @(posedge clk_i) begin
    timer_resp_t act;
    timer_resp_t exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        act = timer_resp_t'(m_axis_tdata_o[13:0]);
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("result %h with nothing outstanding", act));
        end else begin
          exp_r = pending_results.pop_front();
          if (act.status !== exp_r.status || act.granted !== exp_r.granted ||
              act.fired !== exp_r.fired || act.active !== exp_r.active ||
              act.irq !== exp_r.irq)
            note_mismatch($sformatf(
              "expected st=%b gr=%0d fm=%h ac=%b irq=%b, actual st=%b gr=%0d fm=%h ac=%b irq=%b",
              exp_r.status, exp_r.granted, exp_r.fired, exp_r.active, exp_r.irq,
              act.status, act.granted, act.fired, act.active, act.irq));
        end
      end
      if (stall_span == 0) begin
        stall_span = $urandom_range(50, 250);
        stall_style = $urandom_range(0, 2);
      end
      stall_span--;
      case (stall_style)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_run == 0) begin
            stall_run = $urandom_range(1, 12);
            m_axis_tready_i <= ~m_axis_tready_i;
          end
          stall_run--;
        end
      endcase
    end
  end

  initial begin
    #4_000_000;
    $display("multi_channel_soft_timer_bank verification failed");
    $finish;
  end

  initial begin
    logic [31:0] steps[7];
    slot_on_q = '0;
    tick_step_q = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_mode_q[i] = '0;
      slot_period_q[i] = '0;
      slot_left_q[i] = 0;
      slot_shots_q[i] = '0;
    end
    mismatch_cnt = 0;
    burst_left = 0;
    ops_sent = 0;
    firing_ticks = 0;
    full_rejects = 0;
    step_settings = 0;
    stall_span = 0;
    stall_run = 0;
    stall_style = 0;

    add_row(OP_QUERY, 4'd0, '0, MODE_ONESHOT, '0, 1'b1, mk_resp(1'b0, 3'd0, 8'h00, 1'b0, 1'b0));
    add_row(OP_QUERY, 4'd15, '1, MODE_PERIODIC_ALT, '1, 1'b1,
            mk_resp(1'b1, 3'd0, 8'h00, 1'b0, 1'b0));
    add_row(OP_REMOVE, 4'd8, '0, MODE_ONESHOT, '0, 1'b1, mk_resp(1'b1, 3'd0, 8'h00, 1'b0, 1'b0));
    add_row(OP_CHANGE, 4'd3, 32'd7, MODE_ONESHOT, '0, 1'b1,
            mk_resp(1'b1, 3'd0, 8'h00, 1'b0, 1'b0));
    add_row(OP_RSVD_LO, 4'd0, '0, MODE_ONESHOT, '0, 1'b1, mk_resp(1'b1, 3'd0, 8'h00, 1'b0, 1'b0));
    add_row(OP_RSVD_MID, 4'd5, '1, MODE_MULTI, '1, 1'b1, mk_resp(1'b1, 3'd0, 8'h00, 1'b0, 1'b0));
    add_row(OP_RSVD_HI, 4'd15, '1, MODE_PERIODIC_ALT, '1, 1'b1,
            mk_resp(1'b1, 3'd0, 8'h00, 1'b0, 1'b0));
    add_row(OP_TICK, 4'd0, '0, MODE_ONESHOT, '0, 1'b1, mk_resp(1'b0, 3'd0, 8'h00, 1'b0, 1'b0));
    add_row(OP_REMOVE, 4'd2, '0, MODE_ONESHOT, '0, 1'b1, mk_resp(1'b0, 3'd0, 8'h00, 1'b0, 1'b0));
    add_row(OP_ADD, 4'd0, 32'd0, MODE_ONESHOT, 32'd0, 1'b1,
            mk_resp(1'b0, 3'd0, 8'h00, 1'b0, 1'b1));
    add_row(OP_ADD, 4'd0, 32'd3, MODE_MULTI, 32'd0, 1'b1, mk_resp(1'b0, 3'd1, 8'h00, 1'b0, 1'b1));
    add_row(OP_ADD, 4'd0, 32'd2, MODE_MULTI, 32'd3, 1'b1, mk_resp(1'b0, 3'd2, 8'h00, 1'b0, 1'b1));
    add_row(OP_ADD, 4'd15, 32'hFFFF_FFFF, MODE_PERIODIC, 32'hFFFF_FFFF, 1'b1,
            mk_resp(1'b0, 3'd3, 8'h00, 1'b0, 1'b1));
    add_row(OP_ADD, 4'd0, 32'd1, MODE_PERIODIC_ALT, 32'd5, 1'b1,
            mk_resp(1'b0, 3'd4, 8'h00, 1'b0, 1'b1));
    add_row(OP_ADD, 4'd0, 32'd1, MODE_MULTI, 32'd1, 1'b1, mk_resp(1'b0, 3'd5, 8'h00, 1'b0, 1'b1));
    add_row(OP_TICK, 4'd0, '0, MODE_ONESHOT, '0, 1'b0, '0);
    add_row(OP_QUERY, 4'd0, '0, MODE_ONESHOT, '0, 1'b0, '0);
    add_row(OP_CHANGE, 4'd1, 32'hFFFF_FFFF, MODE_ONESHOT, '0, 1'b0, '0);
    add_row(OP_CHANGE, 4'd12, 32'd4, MODE_ONESHOT, '0, 1'b1,
            mk_resp(1'b1, 3'd0, 8'h00, 1'b0, 1'b1));
    for (int i = 0; i < 3; i++) add_row(OP_TICK, 4'd0, '0, MODE_ONESHOT, '0, 1'b0, '0);
    for (int i = 0; i < 5; i++) add_row(OP_ADD, 4'd0, 32'd6, MODE_ONESHOT, 32'd2, 1'b0, '0);
    add_row(OP_REMOVE, 4'd7, '0, MODE_ONESHOT, '0, 1'b0, '0);
    add_row(OP_REMOVE, 4'd7, '0, MODE_ONESHOT, '0, 1'b0, '0);
    add_row(OP_QUERY, 4'd7, '0, MODE_ONESHOT, '0, 1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_tick_step(32'd1);
    foreach (directed_ops[i]) issue_op(directed_ops[i]);
    wait_drained();

    steps[0] = 32'd0;
    steps[1] = 32'd1;
    steps[2] = 32'd3;
    steps[3] = 32'hFFFF_FFFF;
    steps[4] = 32'($urandom);
    steps[5] = 32'($urandom_range(2, 40));
    steps[6] = 32'd1;
    foreach (steps[p]) begin
      program_tick_step(steps[p]);
      for (int n = 0; n < RAND_PER_PHASE; n++) issue_op(random_row(steps[p]));
      wait_drained();
    end

    $display("Sent %0d operations over %0d tick step settings.", ops_sent, step_settings);
    $display("%0d ticks fired at least one slot, %0d adds found the bank full.",
             firing_ticks, full_rejects);
    if (mismatch_cnt == 0) begin
      $display("multi_channel_soft_timer_bank verification clean");
    end else begin
      $display("%0d mismatches in total.", mismatch_cnt);
      $display("multi_channel_soft_timer_bank verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+src
src/mcstb_pkg.sv
src/mcstb_slot_mem.sv
src/mcstb_tick_alu.sv
src/multi_channel_soft_timer_bank.sv
test/multi_channel_soft_timer_bank_test.sv
